### rtl/core/fl_saw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fl_saw_pkg;
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_BUILD = 3'd1,
		PH_WAIT  = 3'd2,
		PH_HOLD  = 3'd3,
		PH_FAIL  = 3'd4,
		PH_DATA  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		CMD_BEGIN = 2'd0,
		CMD_PAYLOAD = 2'd1,
		CMD_RXBYTE = 2'd2,
		CMD_TICK = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_TX = 2'd1,
		KIND_RX = 2'd2
	} byte_kind_t;

	typedef enum logic [1:0] {
		CTL_IDLE = 2'd0,
		CTL_EMIT = 2'd1,
		CTL_RESEND = 2'd2
	} ctl_t;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_AWAIT = 3'd1;
	localparam logic [2:0] ST_FAIL = 3'd2;
	localparam logic [2:0] ST_DATA = 3'd3;
	localparam logic [2:0] ST_REJECT = 3'd4;

	localparam logic [7:0] LEAD_CMD = 8'h11;
	localparam logic [7:0] LEAD_PROTO = 8'h12;
	localparam logic [7:0] BYTE_ACK = 8'h06;
	localparam logic [7:0] BYTE_NAK = 8'h15;
	localparam logic [7:0] BYTE_REPEAT = 8'h52;
	localparam logic [7:0] RESEND_MAX = 8'hFF;

	localparam logic [1:0] REG_RETRY = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_HOLDOFF = 2'd2;
endpackage
`default_nettype wire

### rtl/core/framed_link_stop_and_wait_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Stop-and-wait framed link. Each input transaction yields one or more output
// transactions, one per byte (or one empty result), with last on the final one.
// A begin, payload byte, link byte or tick gives one result per byte it
// produces (up to five for a repeat request: the link byte and four frame
// bytes); a resend streams the stored frame out of the frame RAM at one byte
// per cycle while out_ready is high, with the first read issued at the
// accepting edge. One item is processed at a time; the next input is
// accepted once the last result has been taken.
module framed_link_stop_and_wait_unit #(
	parameter int MAX_PAYLOAD = 60,
	parameter int TICK_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic        frame_kind,
	input  wire logic [5:0]  payload_length,
	input  wire logic [7:0]  value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       byte_kind,
	output logic [7:0]       byte_value,
	output logic [2:0]       link_status,
	output logic [7:0]       retry_count,
	output logic             last,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import fl_saw_pkg::*;

	localparam logic [TICK_WIDTH-1:0] TMAX = '1;
	localparam logic [5:0] MAXP = 6'(MAX_PAYLOAD);

	// configuration
	logic [7:0]  retry_limit_q;
	logic [15:0] timeout_q, holdoff_q;

	// link state
	phase_t phase_q;
	logic [5:0] frame_size_q, payload_left_q;
	logic [7:0] tx_sum_q, resends_q, rx_length_q, rx_sum_q;
	logic [TICK_WIDTH-1:0] elapsed_q;
	logic [8:0] rx_count_q;

	// result sequencer
	ctl_t ctl_q;
	logic [7:0] bytes_q [5];
	logic [2:0] nbytes_q, idx_q;
	logic [1:0] kind_q;
	logic [2:0] status_q;
	logic [5:0] rd_ptr_q;
	logic rd_live_q;

	// ram
	logic ram_we;
	logic [5:0] ram_waddr, ram_raddr;
	logic [7:0] ram_wdata, ram_rdata;

	fl_saw_ram #(.WIDTH(8), .DEPTH(64)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// combinational step of one input
	logic accept;
	phase_t n_phase;
	logic [5:0] n_fsize, n_pleft;
	logic [7:0] n_txsum, n_resends, n_rxlen, n_rxsum;
	logic [TICK_WIDTH-1:0] n_elapsed;
	logic [8:0] n_rxcount;
	logic [7:0] e_bytes [4];
	logic [2:0] e_n;
	logic [1:0] e_kind;
	logic e_resend, e_reject;
	logic [5:0] plen;
	logic [7:0] lead, s;
	logic good;

	assign accept = in_valid && in_ready;
	assign in_ready = (ctl_q == CTL_IDLE);

	always_comb begin
		n_phase = phase_q; n_fsize = frame_size_q; n_pleft = payload_left_q;
		n_txsum = tx_sum_q; n_resends = resends_q; n_rxlen = rx_length_q;
		n_rxsum = rx_sum_q; n_elapsed = elapsed_q; n_rxcount = rx_count_q;
		for (int i = 0; i < 4; i++) e_bytes[i] = 8'd0;
		e_n = 3'd0; e_kind = KIND_TX; e_resend = 1'b0; e_reject = 1'b0;
		plen = (payload_length > MAXP) ? MAXP : payload_length;
		lead = frame_kind ? LEAD_PROTO : LEAD_CMD;
		s = 8'd0; good = 1'b0;
		unique case (cmd_t'(cmd))
			CMD_BEGIN: begin
				if (phase_q == PH_BUILD || phase_q == PH_WAIT || phase_q == PH_HOLD) begin
					e_reject = 1'b1;
				end else begin
					n_resends = 8'd0;
					e_bytes[0] = lead; e_bytes[1] = {2'b00, plen};
					s = lead + {2'b00, plen};
					n_pleft = plen; n_phase = PH_BUILD;
					if (plen == 6'd0) begin
						e_bytes[2] = s; e_n = 3'd3; n_fsize = 6'd3;
						n_txsum = s + s; n_phase = PH_WAIT; n_elapsed = '0;
					end else begin
						e_n = 3'd2; n_fsize = 6'd2; n_txsum = s;
					end
				end
			end
			CMD_PAYLOAD: begin
				if (phase_q == PH_BUILD && payload_left_q != 6'd0) begin
					s = tx_sum_q + value;
					e_bytes[0] = value; n_pleft = payload_left_q - 6'd1;
					if (payload_left_q == 6'd1) begin
						e_bytes[1] = s; e_n = 3'd2; n_fsize = frame_size_q + 6'd2;
						n_txsum = s + s; n_phase = PH_WAIT; n_elapsed = '0;
					end else begin
						e_n = 3'd1; n_fsize = frame_size_q + 6'd1; n_txsum = s;
					end
				end
			end
			CMD_RXBYTE: begin
				if (phase_q == PH_WAIT) begin
					if (value == BYTE_ACK) begin
						n_phase = PH_IDLE; n_resends = 8'd0;
					end else if (resends_q < retry_limit_q) begin
						if (value == BYTE_NAK) begin
							e_resend = 1'b1;
							if (resends_q != RESEND_MAX) n_resends = resends_q + 8'd1;
							n_elapsed = '0; n_phase = PH_WAIT;
						end else begin
							n_phase = PH_HOLD; n_elapsed = '0;
						end
					end else begin
						n_phase = PH_FAIL;
					end
				end else if (phase_q != PH_BUILD && phase_q != PH_HOLD) begin
					e_kind = KIND_RX; e_bytes[0] = value; e_n = 3'd1;
					if (rx_count_q == 9'd1) n_rxlen = value;
					if (rx_count_q >= 9'd2 && rx_count_q == {1'b0, n_rxlen} + 9'd2) begin
						good = (rx_sum_q == value);
						n_rxcount = 9'd0; n_rxsum = 8'd0;
						if (good) begin
							n_phase = PH_DATA;
						end else if (resends_q < retry_limit_q) begin
							// repeat request frame, emitted after the rx byte
							s = LEAD_PROTO + 8'd1 + BYTE_REPEAT;
							n_fsize = 6'd4; n_txsum = s + s; n_pleft = 6'd0;
							n_phase = PH_WAIT; n_elapsed = '0;
							if (resends_q != RESEND_MAX) n_resends = resends_q + 8'd1;
						end
					end else begin
						n_rxsum = rx_sum_q + value; n_rxcount = rx_count_q + 9'd1;
					end
				end
			end
			CMD_TICK: begin
				if (elapsed_q != TMAX) n_elapsed = elapsed_q + 1'b1;
				if (phase_q == PH_WAIT && 32'(n_elapsed) > 32'(timeout_q)) begin
					if (resends_q < retry_limit_q) begin
						n_phase = PH_HOLD; n_elapsed = '0;
					end else begin
						n_phase = PH_FAIL;
					end
				end else if (phase_q == PH_HOLD && 32'(n_elapsed) > 32'(holdoff_q)) begin
					e_resend = 1'b1;
					if (resends_q != RESEND_MAX) n_resends = resends_q + 8'd1;
					n_elapsed = '0; n_phase = PH_WAIT;
				end
			end
			default: ;
		endcase
	end

	// repeat request emits rx byte plus four tx bytes; handled as a flag
	logic rr_q;
	logic rr;
	assign rr = (cmd_t'(cmd) == CMD_RXBYTE) && (n_fsize == 6'd4) && (n_phase == PH_WAIT)
		&& (phase_q != PH_WAIT) && !good && (n_rxcount == 9'd0) && (rx_count_q >= 9'd2);

	// status after processing
	logic [2:0] n_status;
	always_comb begin
		unique case (n_phase)
			PH_WAIT, PH_HOLD: n_status = ST_AWAIT;
			PH_FAIL: n_status = ST_FAIL;
			PH_DATA: n_status = ST_DATA;
			default: n_status = ST_IDLE;
		endcase
		if (e_reject) n_status = ST_REJECT;
	end

	// frame store writes: one per cycle while out_ready is high, during emission of new tx bytes
	logic [5:0] wbase_q;
	logic wr_tx;
	logic [2:0] rr_off;
	assign wr_tx = (ctl_q == CTL_EMIT) && (nbytes_q != 3'd0)
		&& (rr_q ? (idx_q != 3'd0) : (kind_q == KIND_TX));
	assign rr_off = rr_q ? idx_q - 3'd1 : idx_q;
	assign ram_we = wr_tx && out_ready;
	assign ram_waddr = wbase_q + {3'd0, rr_off};
	assign ram_wdata = bytes_q[idx_q];

	// result sequencer
	logic cur_last;
	logic [5:0] nxt_ptr;
	always_comb begin
		cur_last = 1'b0;
		if (ctl_q == CTL_EMIT) cur_last = (idx_q + 3'd1 >= nbytes_q);
		if (ctl_q == CTL_RESEND) cur_last = (rd_ptr_q == frame_size_q);
		nxt_ptr = (rd_live_q && out_ready) ? rd_ptr_q + 6'd1 : rd_ptr_q;
		// first byte of a resend is read at the accepting edge
		ram_raddr = (ctl_q == CTL_RESEND) ? nxt_ptr : 6'd0;
	end

	always_comb begin
		out_valid = 1'b0; byte_kind = KIND_NONE; byte_value = 8'd0; last = cur_last;
		unique case (ctl_q)
			CTL_EMIT: begin
				out_valid = 1'b1;
				if (nbytes_q == 3'd0) begin
					byte_kind = KIND_NONE;
				end else if (rr_q && idx_q == 3'd0) begin
					byte_kind = KIND_RX; byte_value = bytes_q[0];
				end else begin
					byte_kind = rr_q ? KIND_TX : kind_q; byte_value = bytes_q[idx_q];
				end
			end
			CTL_RESEND: begin
				out_valid = rd_live_q;
				byte_kind = KIND_TX; byte_value = ram_rdata;
				last = (rd_ptr_q + 6'd1 == frame_size_q);
			end
			default: ;
		endcase
	end
	assign link_status = status_q;
	assign retry_count = resends_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= 8'd3; timeout_q <= 16'd200; holdoff_q <= 16'd50;
			phase_q <= PH_IDLE; frame_size_q <= '0; payload_left_q <= '0;
			tx_sum_q <= '0; resends_q <= '0; elapsed_q <= '0; rx_count_q <= '0;
			rx_length_q <= '0; rx_sum_q <= '0; ctl_q <= CTL_IDLE; idx_q <= '0;
			nbytes_q <= '0; kind_q <= KIND_NONE; status_q <= ST_IDLE;
			rd_ptr_q <= '0; rd_live_q <= 1'b0; rr_q <= 1'b0; wbase_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_RETRY) retry_limit_q <= cfg_data[7:0];
				else if (cfg_index == REG_TIMEOUT) timeout_q <= cfg_data;
				else if (cfg_index == REG_HOLDOFF) holdoff_q <= cfg_data;
			end
			if (accept) begin
				phase_q <= n_phase; frame_size_q <= n_fsize; payload_left_q <= n_pleft;
				tx_sum_q <= n_txsum; resends_q <= n_resends; elapsed_q <= n_elapsed;
				rx_count_q <= n_rxcount; rx_length_q <= n_rxlen; rx_sum_q <= n_rxsum;
				status_q <= n_status; idx_q <= '0; rr_q <= rr;
				kind_q <= e_kind;
				wbase_q <= (cmd_t'(cmd) == CMD_BEGIN || rr) ? 6'd0 : frame_size_q;
				if (rr) begin
					nbytes_q <= 3'd5;
					bytes_q[0] <= value; bytes_q[1] <= LEAD_PROTO; bytes_q[2] <= 8'd1;
					bytes_q[3] <= BYTE_REPEAT;
					bytes_q[4] <= LEAD_PROTO + 8'd1 + BYTE_REPEAT;
				end else begin
					nbytes_q <= e_n;
					for (int i = 0; i < 4; i++) bytes_q[i] <= e_bytes[i];
					bytes_q[4] <= 8'd0;
				end
				if (e_resend && frame_size_q != 6'd0) begin
					ctl_q <= CTL_RESEND; rd_ptr_q <= '0; rd_live_q <= 1'b1;
				end else begin
					ctl_q <= CTL_EMIT;
				end
			end else if (ctl_q == CTL_EMIT && out_ready) begin
				if (cur_last) ctl_q <= CTL_IDLE;
				idx_q <= idx_q + 3'd1;
			end else if (ctl_q == CTL_RESEND && out_ready) begin
				if (last) begin
					ctl_q <= CTL_IDLE; rd_live_q <= 1'b0;
				end
				rd_ptr_q <= nxt_ptr;
			end
		end
	end

	// during a resend the ram data is valid as soon as CTL_RESEND is entered
	// (raddr is driven with the next pointer, so the ram register holds the current byte)

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("input taken while result pending");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> in_ready) else $error("no return to idle");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> link_status <= ST_REJECT) else $error("bad status");
endmodule
`default_nettype wire

### rtl/core/fl_saw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module fl_saw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire
